// ===== sv/msc_pkg.sv =====
package msc_pkg;

  // default data memory size in bytes, a power of two
  localparam int unsigned MEM_DEPTH = 65536;

  // register file
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = 5;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 136;

  // commands carried in tuser
  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  // halt instruction word
  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  // low three funct bits of an r-type instruction
  localparam logic [2:0] FN_ADDU = 3'd1;
  localparam logic [2:0] FN_SUBU = 3'd3;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_OR   = 3'd5;
  localparam logic [2:0] FN_NOR  = 3'd7;

  // write requests from the core to the data memory
  typedef struct packed {
    logic store;
    logic preload;
  } dmem_ctrl_t;

  // r-type operation, unused codes give zero
  function automatic logic [31:0] alu(input logic [2:0] sel, input logic [31:0] a,
                                      input logic [31:0] b);
    logic [31:0] res;
    case (sel)
      FN_ADDU: res = a + b;
      FN_SUBU: res = a - b;
      FN_AND:  res = a & b;
      FN_OR:   res = a | b;
      FN_NOR:  res = ~(a | b);
      default: res = 32'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/msc_ram.sv =====
module msc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/msc_data_mem.sv =====
module msc_data_mem #(
  parameter int unsigned MEM_DEPTH = msc_pkg::MEM_DEPTH,
  localparam int unsigned AW       = $clog2(MEM_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msc_pkg::dmem_ctrl_t ctrl_i,
  input  logic [AW-1:0]       waddr_i,    // store word address
  input  logic [31:0]         wdata_i,    // store word, big-endian
  input  logic [AW-1:0]       pl_addr_i,  // preload byte address
  input  logic [7:0]          pl_byte_i,
  input  logic [AW-1:0]       raddr_i,    // load word address
  output logic [31:0]         rdata_o,    // load word, registered, valid the cycle after raddr_i
  output logic                busy_o      // clearing after reset
);

  localparam int unsigned ROWS = MEM_DEPTH / 4;
  localparam int unsigned RAW  = $clog2(ROWS);

  logic           clr_busy_q;
  logic [RAW-1:0] clr_row_q;
  logic [1:0]     off_q;
  logic [7:0]     bank_rdata [4];

  // clearing sweep, one row of four bytes per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      clr_row_q <= clr_row_q + RAW'(1);
      if (clr_row_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = clr_busy_q;

  // four byte lanes, lane n holds the bytes whose address ends in n
  for (genvar g = 0; g < 4; g++) begin : g_bank
    localparam logic [1:0] Lane = 2'(g);

    logic [1:0]     st_k;
    logic [RAW-1:0] st_row;
    logic [RAW-1:0] rd_row;
    logic [RAW-1:0] wr_row;
    logic [7:0]     st_byte;
    logic [7:0]     wr_byte;
    logic           we;

    // lane steering for stores, loads and preloads, rows wrap at the end
    always_comb begin
      st_k    = Lane - waddr_i[1:0];
      st_row  = waddr_i[AW-1:2] + RAW'(Lane < waddr_i[1:0]);
      st_byte = wdata_i[{~st_k, 3'b000} +: 8];
      rd_row  = raddr_i[AW-1:2] + RAW'(Lane < raddr_i[1:0]);
      we      = clr_busy_q || ctrl_i.store || (ctrl_i.preload && (pl_addr_i[1:0] == Lane));
      if (clr_busy_q) begin
        wr_row  = clr_row_q;
        wr_byte = 8'd0;
      end else if (ctrl_i.store) begin
        wr_row  = st_row;
        wr_byte = st_byte;
      end else begin
        wr_row  = pl_addr_i[AW-1:2];
        wr_byte = pl_byte_i;
      end
    end

    msc_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (wr_row),
      .wdata_i (wr_byte),
      .raddr_i (rd_row),
      .rdata_o (bank_rdata[g])
    );
  end

  // byte offset of the read in flight
  always_ff @(posedge clk_i) begin
    off_q <= raddr_i[1:0];
  end

  // most significant byte comes from the lowest address
  always_comb begin
    logic [1:0] lane;
    rdata_o = '0;
    for (int k = 0; k < 4; k++) begin
      lane = off_q + 2'(k);
      rdata_o[31-8*k -: 8] = bank_rdata[lane];
    end
  end

endmodule

// ===== sv/mips_subset_core_step.sv =====
// MIPS32 subset core: one instruction or data memory preload per input transfer, with one
// result transfer per input giving register write, memory write, next pc and halt flag.
// It sustains one transfer per clock unless the result side stalls or the data memory is
// being cleared; an input passes the execute stage, memory stage and output register in
// turn, and results of loads are forwarded from the memory read straight into the next
// instruction's operands, so no sequence of instructions stalls. The register file sits in
// two copies of a 32 x 32 synchronous memory and data memory in four byte-wide banks of
// MEM_DEPTH/4 rows, so an unaligned or wrapping word is read or written in one access.
// MEM_DEPTH must be a power of two. After reset the data memory is cleared row by row;
// input is not taken until that is done.
module mips_subset_core_step #(
  parameter int unsigned MEM_DEPTH = msc_pkg::MEM_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // instruction [31:0], load_address [47:32], load_byte [55:48]
  input  logic [msc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command [0]
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // reg_write_enable [0], reg_write_index [5:1], reg_write_value [37:6],
  // mem_write_enable [38], mem_write_address [70:39], mem_write_value [102:71],
  // next_pc [134:103], halted [135]
  output logic [msc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // handshake and stage control
  logic in_xfer;
  logic out_en, s2_en, s1_en;
  logic s1_move, s2_move;

  // execute stage
  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [31:0] s1_ins_q;
  logic [15:0] s1_la_q;
  logic [7:0]  s1_lb_q;

  // memory stage
  logic                      s2_valid_q;
  logic                      s2_wr_q;
  logic [msc_pkg::REG_AW-1:0] s2_dest_q;
  logic [31:0]               s2_val_q;
  logic                      s2_load_q;
  logic                      s2_mwe_q;
  logic [31:0]               s2_mwa_q;
  logic [31:0]               s2_mwv_q;
  logic [AW-1:0]             s2_addr_q;
  logic [31:0]               s2_pc_q;
  logic                      s2_halted_q;
  logic [31:0]               s2_value;

  // output register
  logic                              out_valid_q;
  logic [msc_pkg::OUT_DATA_W-1:0]    out_data_q;
  logic [msc_pkg::OUT_DATA_W-1:0]    out_data_d;

  // architectural state outside the memories
  logic [31:0]                  pc_q;
  logic                         halt_q;
  logic [msc_pkg::REG_COUNT-1:0] rf_valid_q;
  logic                         wb_valid_q;
  logic [msc_pkg::REG_AW-1:0]   wb_idx_q;
  logic [31:0]                  wb_val_q;

  // decode and execute
  logic [5:0]                 op;
  logic [msc_pkg::REG_AW-1:0] rs, rt, rd;
  logic [msc_pkg::REG_AW-1:0] rs_rd, rt_rd;
  logic [31:0]                sext, sum, pc4, opa, opb;
  logic [31:0]                rf_a, rf_b;
  logic                       exec, halt_hit, run;
  logic                       wr, is_load, is_store;
  logic [msc_pkg::REG_AW-1:0] dest;
  logic [31:0]                val, next;
  logic [31:0]                la_ext;

  // register file write port
  logic                       rf_we;

  // data memory
  msc_pkg::dmem_ctrl_t dmem_ctrl;
  logic [AW-1:0]       dmem_raddr;
  logic [31:0]         dmem_rdata;
  logic                dmem_busy;

  // operand with forwarding from the memory stage and the last write
  function automatic logic [31:0] operand(
    input logic [msc_pkg::REG_AW-1:0] idx,
    input logic [31:0]                ram,
    input logic                       ram_ok,
    input logic                       s2_hit,
    input logic [31:0]                s2_v,
    input logic                       wb_hit,
    input logic [31:0]                wb_v
  );
    logic [31:0] res;
    if (idx == '0) begin
      res = 32'd0;
    end else if (s2_hit) begin
      res = s2_v;
    end else if (wb_hit) begin
      res = wb_v;
    end else if (ram_ok) begin
      res = ram;
    end else begin
      res = 32'd0;
    end
    return res;
  endfunction

  // stage enables, a stage moves when the next one is empty or moving
  assign out_en        = !out_valid_q || m_axis_tready;
  assign s2_en         = !s2_valid_q || out_en;
  assign s1_en         = !s1_valid_q || s2_en;
  assign s1_move       = s1_valid_q && s2_en;
  assign s2_move       = s2_valid_q && out_en;
  assign s_axis_tready = s1_en && !dmem_busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // register file reads, repeated for a held instruction
  assign rs_rd = s1_en ? s_axis_tdata[25:21] : s1_ins_q[25:21];
  assign rt_rd = s1_en ? s_axis_tdata[20:16] : s1_ins_q[20:16];

  msc_ram #(
    .WIDTH (32),
    .DEPTH (msc_pkg::REG_COUNT)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_dest_q),
    .wdata_i (s2_value),
    .raddr_i (rs_rd),
    .rdata_o (rf_a)
  );

  msc_ram #(
    .WIDTH (32),
    .DEPTH (msc_pkg::REG_COUNT)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_dest_q),
    .wdata_i (s2_value),
    .raddr_i (rt_rd),
    .rdata_o (rf_b)
  );

  // execute stage input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q <= s_axis_tuser[0];
      s1_ins_q <= s_axis_tdata[31:0];
      s1_la_q  <= s_axis_tdata[47:32];
      s1_lb_q  <= s_axis_tdata[55:48];
    end
  end

  // field extraction and operands
  always_comb begin
    op   = s1_ins_q[31:26];
    rs   = s1_ins_q[25:21];
    rt   = s1_ins_q[20:16];
    rd   = s1_ins_q[15:11];
    sext = {{16{s1_ins_q[15]}}, s1_ins_q[15:0]};
    opa  = operand(rs, rf_a, rf_valid_q[rs],
                   s2_valid_q && s2_wr_q && (s2_dest_q == rs), s2_value,
                   wb_valid_q && (wb_idx_q == rs), wb_val_q);
    opb  = operand(rt, rf_b, rf_valid_q[rt],
                   s2_valid_q && s2_wr_q && (s2_dest_q == rt), s2_value,
                   wb_valid_q && (wb_idx_q == rt), wb_val_q);
    sum  = opa + sext;
    pc4  = pc_q + 32'd4;
    la_ext = {16'd0, s1_la_q};
  end

  // decode
  always_comb begin
    exec     = (s1_cmd_q == msc_pkg::CMD_EXEC) && !halt_q;
    halt_hit = exec && (s1_ins_q == msc_pkg::HALT_WORD);
    run      = exec && !halt_hit;
    wr       = 1'b0;
    is_load  = 1'b0;
    is_store = 1'b0;
    dest     = rt;
    val      = sum;
    next     = pc4;
    case (op)
      msc_pkg::OP_RTYPE: begin
        wr   = 1'b1;
        dest = rd;
        val  = msc_pkg::alu(s1_ins_q[2:0], opa, opb);
      end
      msc_pkg::OP_ADDIU: begin
        wr = 1'b1;
      end
      msc_pkg::OP_LW: begin
        wr      = 1'b1;
        is_load = 1'b1;
      end
      msc_pkg::OP_SW: begin
        is_store = 1'b1;
      end
      msc_pkg::OP_BEQ: begin
        if (opa == opb) begin
          next = pc4 + {sext[29:0], 2'b00};
        end
      end
      msc_pkg::OP_J: begin
        next = {pc4[31:28], s1_ins_q[25:0], 2'b00};
      end
      default: begin
        next = pc4;
      end
    endcase
  end

  // pc and halt flag follow the instruction order in the execute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
    end else if (s1_move) begin
      if (halt_hit) begin
        halt_q <= 1'b1;
      end
      if (run) begin
        pc_q <= next;
      end
    end
  end

  // data memory, a held load keeps its read going
  assign dmem_ctrl.store   = s1_move && run && is_store;
  assign dmem_ctrl.preload = s1_move && (s1_cmd_q == msc_pkg::CMD_PRELOAD);
  assign dmem_raddr        = (s2_valid_q && !out_en) ? s2_addr_q : sum[AW-1:0];

  msc_data_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (dmem_ctrl),
    .waddr_i   (sum[AW-1:0]),
    .wdata_i   (opb),
    .pl_addr_i (la_ext[AW-1:0]),
    .pl_byte_i (s1_lb_q),
    .raddr_i   (dmem_raddr),
    .rdata_o   (dmem_rdata),
    .busy_o    (dmem_busy)
  );

  // memory stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_wr_q     <= run && wr && (dest != '0);
      s2_dest_q   <= dest;
      s2_val_q    <= val;
      s2_load_q   <= is_load;
      s2_mwe_q    <= run && is_store;
      s2_mwa_q    <= (run && is_store) ? sum : 32'd0;
      s2_mwv_q    <= (run && is_store) ? opb : 32'd0;
      s2_addr_q   <= sum[AW-1:0];
      s2_pc_q     <= run ? next : pc_q;
      s2_halted_q <= halt_q || halt_hit;
    end
  end

  assign s2_value = s2_load_q ? dmem_rdata : s2_val_q;
  assign rf_we    = s2_move && s2_wr_q;

  // register write-back, valid bits and the last write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
      wb_valid_q <= 1'b0;
    end else if (rf_we) begin
      rf_valid_q[s2_dest_q] <= 1'b1;
      wb_valid_q            <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      wb_idx_q <= s2_dest_q;
      wb_val_q <= s2_value;
    end
  end

  // result packing
  always_comb begin
    out_data_d          = '0;
    out_data_d[0]       = s2_wr_q;
    out_data_d[5:1]     = s2_wr_q ? s2_dest_q : '0;
    out_data_d[37:6]    = s2_wr_q ? s2_value : 32'd0;
    out_data_d[38]      = s2_mwe_q;
    out_data_d[70:39]   = s2_mwa_q;
    out_data_d[102:71]  = s2_mwv_q;
    out_data_d[134:103] = s2_pc_q;
    out_data_d[135]     = s2_halted_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // halt is final and freezes the pc
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  a_pc_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> (pc_q == $past(pc_q)))
    else $error("pc moved while halted");

  // register zero is never written
  a_no_zero_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (s2_dest_q != '0))
    else $error("write to register zero");

  // nothing in flight while the data memory is cleared
  a_idle_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dmem_busy |-> (!s1_valid_q && !s2_valid_q && !out_valid_q))
    else $error("instruction in flight during clearing");

  // a result without a register write carries a zero index and value
  a_quiet_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[37:1] == '0))
    else $error("register write fields set without enable");

endmodule

// ===== sim/mips_subset_core_step_test.sv =====
`timescale 1ns / 100ps

module mips_subset_core_step_test;

  // result transfer layout, last declared field in the lowest bits
  typedef struct packed {
    logic        halted;
    logic [31:0] next_pc;
    logic [31:0] mem_write_value;
    logic [31:0] mem_write_address;
    logic        mem_write_enable;
    logic [31:0] reg_write_value;
    logic [4:0]  reg_write_index;
    logic        reg_write_enable;
  } core_result_t;

  // architectural state of the core and the queue of results it should produce
  class core_scoreboard;
    logic [31:0]  regs [msc_pkg::REG_COUNT];
    logic [7:0]   dmem [msc_pkg::MEM_DEPTH];
    logic [31:0]  pc;
    logic         halt;
    core_result_t pending_results [$];
    int n_items, n_preloads, n_loads, n_stores, n_taken, n_jumps, n_ignored;
    int n_checked, n_errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc   = '0;
      halt = 1'b0;
    endfunction

    function automatic logic [31:0] rtype_value(logic [2:0] sel, logic [31:0] a,
                                                 logic [31:0] b);
      case (sel)
        msc_pkg::FN_ADDU: return a + b;
        msc_pkg::FN_SUBU: return a - b;
        msc_pkg::FN_AND:  return a & b;
        msc_pkg::FN_OR:   return a | b;
        msc_pkg::FN_NOR:  return ~(a | b);
        default: return '0;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // step the core on an accepted input transfer
    function void note_input(logic cmd, logic [31:0] ins, logic [15:0] ld_addr,
                             logic [7:0] ld_byte);
      core_result_t r;
      logic [5:0]   op;
      logic [4:0]   rs, rt, rd, dest;
      logic [31:0]  imm_x, a, b, pc_plus4, nxt, val, ea;
      logic         wr;
      r  = '0;
      wr = 1'b0;
      n_items++;
      if (cmd == msc_pkg::CMD_PRELOAD) begin
        dmem[ld_addr % msc_pkg::MEM_DEPTH] = ld_byte;
        n_preloads++;
      end else if (halt) begin
        n_ignored++;
      end else if (ins == msc_pkg::HALT_WORD) begin
        halt = 1'b1;
      end else begin
        op       = ins[31:26];
        rs       = ins[25:21];
        rt       = ins[20:16];
        rd       = ins[15:11];
        imm_x    = {{16{ins[15]}}, ins[15:0]};
        a        = regs[rs];
        b        = regs[rt];
        pc_plus4 = pc + 32'd4;
        nxt      = pc_plus4;
        dest     = '0;
        val      = '0;
        ea       = a + imm_x;
        case (op)
          msc_pkg::OP_RTYPE: begin
            dest = rd;
            val  = rtype_value(ins[2:0], a, b);
            wr   = 1'b1;
          end
          msc_pkg::OP_ADDIU: begin
            dest = rt;
            val  = ea;
            wr   = 1'b1;
          end
          msc_pkg::OP_LW: begin
            // big-endian word, each byte address wraps on its own
            for (int k = 0; k < 4; k++)
              val = {val[23:0], dmem[(ea + k) % msc_pkg::MEM_DEPTH]};
            dest = rt;
            wr   = 1'b1;
            n_loads++;
          end
          msc_pkg::OP_SW: begin
            for (int k = 0; k < 4; k++)
              dmem[(ea + k) % msc_pkg::MEM_DEPTH] = b[31 - 8 * k -: 8];
            r.mem_write_enable  = 1'b1;
            r.mem_write_address = ea;
            r.mem_write_value   = b;
            n_stores++;
          end
          msc_pkg::OP_BEQ: begin
            if (a == b) begin
              nxt = pc_plus4 + (imm_x << 2);
              n_taken++;
            end
          end
          msc_pkg::OP_J: begin
            nxt = {pc_plus4[31:28], ins[25:0], 2'b00};
            n_jumps++;
          end
          default: ;
        endcase
        // writes to register zero are dropped
        if (wr && dest != '0) begin
          regs[dest]        = val;
          r.reg_write_enable = 1'b1;
          r.reg_write_index  = dest;
          r.reg_write_value  = val;
        end
        pc = nxt;
      end
      r.next_pc = pc;
      r.halted  = halt;
      pending_results.push_back(r);
    endfunction

    // compare one result transfer with the oldest prediction
    function void check_result(core_result_t got);
      core_result_t want;
      string        bad;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transfer %h", got);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      bad = "";
      if (got.reg_write_enable !== want.reg_write_enable) bad = {bad, " reg_write_enable"};
      if (got.reg_write_index !== want.reg_write_index) bad = {bad, " reg_write_index"};
      if (got.reg_write_value !== want.reg_write_value) bad = {bad, " reg_write_value"};
      if (got.mem_write_enable !== want.mem_write_enable) bad = {bad, " mem_write_enable"};
      if (got.mem_write_address !== want.mem_write_address) bad = {bad, " mem_write_address"};
      if (got.mem_write_value !== want.mem_write_value) bad = {bad, " mem_write_value"};
      if (got.next_pc !== want.next_pc) bad = {bad, " next_pc"};
      if (got.halted !== want.halted) bad = {bad, " halted"};
      if (bad != "") begin
        n_errors++;
        if (n_errors <= 10)
          $display("result %0d mismatch in%s: expected %h got %h", n_checked, bad, want, got);
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [msc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]                     s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [msc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  core_scoreboard sb = new();
  int             sent_count = 0;
  logic [4:0]     last_store_rs = '0;
  logic [15:0]    last_store_imm = '0;

  mips_subset_core_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 2);
    else if (r < 97) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // small register pool most of the time so results feed later operands
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 99) < 60) return 5'($urandom_range(0, 7));
    else return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [10:0] low);
    return {msc_pkg::OP_RTYPE, rs, rt, rd, low};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // offer one input transfer after a random gap (none in burst windows) and wait for it to be taken
  task automatic send_item(input logic cmd, input logic [31:0] ins,
                           input logic [15:0] ld_addr, input logic [7:0] ld_byte);
    int gap;
    gap = ((sent_count / 200) % 4 == 2) ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ld_byte, ld_addr, ins};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, ins, ld_addr, ld_byte);
    sent_count++;
  endtask

  task automatic send_exec(input logic [31:0] ins);
    send_item(msc_pkg::CMD_EXEC, ins, 16'($urandom), 8'($urandom));
  endtask

  // field extremes, every operation and the corner cases
  task automatic run_directed();
    send_item(msc_pkg::CMD_PRELOAD, '0, 16'hFFFF, 8'hFF);
    send_item(msc_pkg::CMD_PRELOAD, '1, 16'h0000, 8'hA5);
    send_item(msc_pkg::CMD_PRELOAD, '0, 16'h0001, 8'h5A);
    send_exec(enc_i(msc_pkg::OP_ADDIU, 5'd0, 5'd1, 16'h7FFF));
    send_exec(enc_i(msc_pkg::OP_ADDIU, 5'd0, 5'd2, 16'h8000));
    send_exec(enc_i(msc_pkg::OP_ADDIU, 5'd1, 5'd0, 16'h0005));
    send_exec(enc_r(5'd1, 5'd2, 5'd3, 11'h021));
    send_exec(enc_r(5'd1, 5'd2, 5'd4, 11'h023));
    send_exec(enc_r(5'd1, 5'd2, 5'd5, 11'h024));
    send_exec(enc_r(5'd1, 5'd2, 5'd6, 11'h025));
    send_exec(enc_r(5'd1, 5'd2, 5'd7, 11'h027));
    // funct codes that select nothing write zero
    send_exec(enc_r(5'd1, 5'd2, 5'd8, 11'h000));
    send_exec(enc_r(5'd31, 5'd31, 5'd12, 11'h7FE));
    send_exec(enc_r(5'd1, 5'd2, 5'd0, 11'h025));
    send_exec(enc_i(msc_pkg::OP_ADDIU, 5'd0, 5'd9, 16'hFFFF));
    // word access wrapping round the end of data memory
    send_exec(enc_i(msc_pkg::OP_LW, 5'd0, 5'd10, 16'hFFFE));
    send_exec(enc_i(msc_pkg::OP_SW, 5'd0, 5'd9, 16'hFFFD));
    send_exec(enc_i(msc_pkg::OP_LW, 5'd0, 5'd11, 16'hFFFD));
    send_exec(enc_i(msc_pkg::OP_BEQ, 5'd1, 5'd1, 16'h0003));
    send_exec(enc_i(msc_pkg::OP_BEQ, 5'd1, 5'd2, 16'hFFFF));
    send_exec(enc_i(msc_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
    send_exec({msc_pkg::OP_J, 26'h3FF_FFFF});
    send_exec({msc_pkg::OP_J, 26'h000_0000});
    send_exec(32'hFC00_0000);
  endtask

  // random instruction mix, with loads often reusing the last store address
  task automatic run_random(input int count);
    int          r;
    logic [4:0]  rs, rt;
    logic [15:0] imm;
    logic [31:0] w;
    logic [25:0] tgt;
    logic [5:0]  op;
    for (int i = 0; i < count; i++) begin
      r   = $urandom_range(0, 99);
      rs  = pick_reg();
      rt  = pick_reg();
      imm = 16'($urandom);
      tgt = 26'($urandom);
      if (r < 8) begin
        send_item(msc_pkg::CMD_PRELOAD, $urandom, 16'($urandom), 8'($urandom));
      end else begin
        if ((r >= 50 && r < 74) && $urandom_range(0, 5) == 0) begin
          rs  = '0;
          imm = 16'hFFFC | 16'($urandom_range(0, 3));
        end
        if (r < 30) begin
          w = enc_r(rs, rt, pick_reg(), 11'($urandom));
        end else if (r < 50) begin
          w = enc_i(msc_pkg::OP_ADDIU, rs, rt, imm);
        end else if (r < 62) begin
          if ($urandom_range(0, 2) == 0) begin
            rs  = last_store_rs;
            imm = last_store_imm;
          end
          w = enc_i(msc_pkg::OP_LW, rs, rt, imm);
        end else if (r < 74) begin
          last_store_rs  = rs;
          last_store_imm = imm;
          w = enc_i(msc_pkg::OP_SW, rs, rt, imm);
        end else if (r < 84) begin
          if ($urandom_range(0, 1) == 1) rt = rs;
          w = enc_i(msc_pkg::OP_BEQ, rs, rt, imm);
        end else if (r < 90) begin
          w = {msc_pkg::OP_J, tgt};
        end else if (r < 95) begin
          do op = 6'($urandom);
          while (op inside {msc_pkg::OP_RTYPE, msc_pkg::OP_J, msc_pkg::OP_BEQ,
                            msc_pkg::OP_ADDIU, msc_pkg::OP_LW, msc_pkg::OP_SW});
          w = {op, tgt};
        end else begin
          w = $urandom;
          if (w == msc_pkg::HALT_WORD) w = '0;
        end
        send_exec(w);
      end
    end
  endtask

  // halt, then show that execution is ignored, also around a preload sent while halted
  task automatic run_halt_tail();
    send_exec(msc_pkg::HALT_WORD);
    send_exec(enc_i(msc_pkg::OP_ADDIU, 5'd0, 5'd1, 16'h1234));
    send_item(msc_pkg::CMD_PRELOAD, '0, 16'h8000, 8'hC3);
    send_exec(enc_i(msc_pkg::OP_LW, 5'd0, 5'd2, 16'h8000));
    send_exec(msc_pkg::HALT_WORD);
  endtask

  // result side: random stalls, burst windows and one long hold-off
  initial begin
    int hold;
    int cyc;
    bit pressed;
    hold          = 0;
    cyc           = 0;
    pressed       = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (!pressed && sb.n_checked >= 400) begin
        pressed = 1'b1;
        hold    = 400;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else if ((cyc / 500) % 4 == 1 || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        hold = pick_gap();
        m_axis_tready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  // check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // stimulus and end of run
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = msc_pkg::CMD_EXEC;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random(1300);
    run_halt_tail();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("ran %0d transfers: %0d preloads, %0d loads, %0d stores, %0d taken branches,",
             sb.n_items, sb.n_preloads, sb.n_loads, sb.n_stores, sb.n_taken);
    $display("%0d jumps, %0d ignored while halted; %0d results checked, %0d mismatches",
             sb.n_jumps, sb.n_ignored, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
